// File: hw/rtl/cube_shell_position_enumerator_core_defines.svh
// assertion macros for the cube shell position enumerator
`ifndef CUBE_SHELL_POSITION_ENUMERATOR_CORE_DEFINES_SVH
`define CUBE_SHELL_POSITION_ENUMERATOR_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CSP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CSP_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define CSP_ASSERT(lbl, prop, msg)
`define CSP_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: hw/rtl/csp_pkg.sv
// types, constants and the radius-one table of the cube shell position enumerator
`default_nettype none
package csp_pkg;
	localparam int MAX_RADIUS = 255;
	localparam int RAD_W = 8;
	localparam int COORD_W = 9;
	localparam int TABLE_LEN = 26;

	typedef enum logic [2:0] {
		SEC_ORIGIN,
		SEC_TABLE,
		SEC_SIDEX,
		SEC_SIDEZ,
		SEC_FACES
	} section_t;

	typedef struct packed {
		logic signed [1:0] x;
		logic signed [1:0] y;
		logic signed [1:0] z;
	} unit_pos_t;

	// faces, then edges, then corners
	localparam unit_pos_t UNIT_SHELL [TABLE_LEN] = '{
		'{2'sd0, 2'sd1, 2'sd0}, '{2'sd0, 2'sd0, 2'sd1}, '{-2'sd1, 2'sd0, 2'sd0},
		'{2'sd1, 2'sd0, 2'sd0}, '{2'sd0, 2'sd0, -2'sd1}, '{2'sd0, -2'sd1, 2'sd0},
		'{-2'sd1, 2'sd0, 2'sd1}, '{2'sd1, 2'sd0, 2'sd1}, '{-2'sd1, 2'sd0, -2'sd1},
		'{2'sd1, 2'sd0, -2'sd1}, '{-2'sd1, -2'sd1, 2'sd0}, '{2'sd1, -2'sd1, 2'sd0},
		'{2'sd0, -2'sd1, 2'sd1}, '{2'sd0, -2'sd1, -2'sd1}, '{-2'sd1, 2'sd1, 2'sd0},
		'{2'sd1, 2'sd1, 2'sd0}, '{2'sd0, 2'sd1, 2'sd1}, '{2'sd0, 2'sd1, -2'sd1},
		'{-2'sd1, 2'sd1, 2'sd1}, '{2'sd1, 2'sd1, 2'sd1}, '{-2'sd1, 2'sd1, -2'sd1},
		'{2'sd1, 2'sd1, -2'sd1}, '{-2'sd1, -2'sd1, 2'sd1}, '{2'sd1, -2'sd1, 2'sd1},
		'{-2'sd1, -2'sd1, -2'sd1}, '{2'sd1, -2'sd1, -2'sd1}
	};
endpackage
`default_nettype wire

// File: hw/rtl/cube_shell_position_enumerator_core.sv
// latency: a position appears on m_tdata the cycle after its request beat is taken
// throughput: one position per cycle while m_tready is high; the output register frees as
// it is read, so s_tready stays high while the result beat is taken in the same cycle
// the rate is set by the single pass from the shell counters to the output register
// reset: shell counters return to the origin sequence with radius zero, no beat pending
`default_nettype none
`include "cube_shell_position_enumerator_core_defines.svh"
module cube_shell_position_enumerator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // radius[7:0]
	input  wire logic        s_tuser,  // restart
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // pos_x[8:0], pos_y[17:9], pos_z[26:18], zero pad
	output logic             m_tlast   // last
);
	localparam int RW = csp_pkg::RAD_W;
	localparam int CW = csp_pkg::COORD_W;

	// shell counters
	logic [RW-1:0]         held_radius_q;
	csp_pkg::section_t     section_q;
	logic [RW-1:0]         slice_y_q;
	logic signed [CW-1:0]  inner_q;
	logic signed [CW-1:0]  outer_q;
	logic [1:0]            emit_slot_q;
	logic [4:0]            table_index_q;

	// output register
	logic                  m_valid_q;
	logic signed [CW-1:0]  pos_x_q, pos_y_q, pos_z_q;
	logic                  last_q;

	// counters as seen by the current beat, after a restart
	logic [RW-1:0]         cur_rad;
	csp_pkg::section_t     cur_sec;
	logic [RW-1:0]         cur_slice;
	logic signed [CW-1:0]  cur_inner, cur_outer;
	logic [1:0]            cur_slot;
	logic [4:0]            cur_tidx;

	logic [RW-1:0]         in_rad;
	logic signed [CW-1:0]  d9, neg_d9;
	logic signed [CW-1:0]  slice9;
	csp_pkg::section_t     begin_sec;
	logic signed [CW-1:0]  out_x, out_y, out_z;
	logic                  out_last;
	logic [4:0]            tidx_clamp;
	csp_pkg::unit_pos_t    upos;

	csp_pkg::section_t     nxt_sec;
	logic [RW-1:0]         nxt_slice;
	logic signed [CW-1:0]  nxt_inner, nxt_outer;
	logic [1:0]            nxt_slot;
	logic [4:0]            nxt_tidx;
	logic                  slot_wrap;
	logic                  take;

	assign s_tready = !m_valid_q || m_tready;
	assign take     = s_tvalid && s_tready;

	assign in_rad = (s_tdata > RW'(csp_pkg::MAX_RADIUS)) ? RW'(csp_pkg::MAX_RADIUS) : s_tdata;

	always_comb begin
		if (s_tuser) begin
			cur_rad   = in_rad;
			cur_slice = '0;
			cur_slot  = '0;
			cur_tidx  = '0;
			cur_inner = -$signed({1'b0, in_rad});
			cur_outer = -$signed({1'b0, in_rad});
			if (in_rad == '0) begin
				cur_sec = csp_pkg::SEC_ORIGIN;
			end else if (in_rad == RW'(1)) begin
				cur_sec = csp_pkg::SEC_TABLE;
			end else begin
				cur_sec = csp_pkg::SEC_SIDEX;
			end
		end else begin
			cur_rad   = held_radius_q;
			cur_sec   = section_q;
			cur_slice = slice_y_q;
			cur_slot  = emit_slot_q;
			cur_tidx  = table_index_q;
			cur_inner = inner_q;
			cur_outer = outer_q;
		end
	end

	assign d9     = $signed({1'b0, cur_rad});
	assign neg_d9 = -d9;
	assign slice9 = $signed({1'b0, cur_slice});

	always_comb begin
		if (cur_rad == '0) begin
			begin_sec = csp_pkg::SEC_ORIGIN;
		end else if (cur_rad == RW'(1)) begin
			begin_sec = csp_pkg::SEC_TABLE;
		end else begin
			begin_sec = csp_pkg::SEC_SIDEX;
		end
	end

	assign tidx_clamp = (cur_tidx < 5'(csp_pkg::TABLE_LEN)) ? cur_tidx
		: 5'(csp_pkg::TABLE_LEN - 1);
	assign upos = csp_pkg::UNIT_SHELL[tidx_clamp];

	// position of the current beat
	always_comb begin
		out_x    = '0;
		out_y    = cur_slot[1] ? -slice9 : slice9;
		out_z    = '0;
		out_last = 1'b0;
		case (cur_sec)
			csp_pkg::SEC_TABLE: begin
				out_x    = CW'(upos.x);
				out_y    = CW'(upos.y);
				out_z    = CW'(upos.z);
				out_last = (tidx_clamp == 5'(csp_pkg::TABLE_LEN - 1));
			end
			csp_pkg::SEC_SIDEX: begin
				out_x = cur_slot[0] ? neg_d9 : d9;
				out_z = cur_inner;
			end
			csp_pkg::SEC_SIDEZ: begin
				out_x = cur_inner;
				out_z = cur_slot[0] ? neg_d9 : d9;
			end
			csp_pkg::SEC_FACES: begin
				out_x    = cur_outer;
				out_y    = cur_slot[0] ? d9 : neg_d9;
				out_z    = cur_inner;
				out_last = (cur_outer >= d9) && (cur_inner >= d9) && cur_slot[0];
			end
			default: begin
				out_y    = '0;
				out_last = 1'b1;
			end
		endcase
	end

	// counter advance
	always_comb begin
		nxt_sec   = cur_sec;
		nxt_slice = cur_slice;
		nxt_inner = cur_inner;
		nxt_outer = cur_outer;
		nxt_slot  = cur_slot;
		nxt_tidx  = cur_tidx;
		slot_wrap = (cur_slice != '0) ? (cur_slot == 2'd3) : (cur_slot == 2'd1);
		if (out_last) begin
			nxt_sec   = begin_sec;
			nxt_slice = '0;
			nxt_inner = neg_d9;
			nxt_outer = neg_d9;
			nxt_slot  = '0;
			nxt_tidx  = '0;
		end else begin
			case (cur_sec)
				csp_pkg::SEC_TABLE: begin
					nxt_tidx = cur_tidx + 5'd1;
				end
				csp_pkg::SEC_SIDEX: begin
					if (slot_wrap) begin
						nxt_slot = '0;
						if (cur_inner == d9) begin
							nxt_inner = CW'(1) - d9;
							nxt_sec   = csp_pkg::SEC_SIDEZ;
						end else begin
							nxt_inner = cur_inner + CW'(1);
						end
					end else begin
						nxt_slot = cur_slot + 2'd1;
					end
				end
				csp_pkg::SEC_SIDEZ: begin
					if (slot_wrap) begin
						nxt_slot = '0;
						if (cur_inner == d9 - CW'(1)) begin
							nxt_slice = cur_slice + RW'(1);
							nxt_inner = neg_d9;
							if (cur_slice == cur_rad - RW'(1)) begin
								nxt_outer = neg_d9;
								nxt_sec   = csp_pkg::SEC_FACES;
							end else begin
								nxt_sec = csp_pkg::SEC_SIDEX;
							end
						end else begin
							nxt_inner = cur_inner + CW'(1);
						end
					end else begin
						nxt_slot = cur_slot + 2'd1;
					end
				end
				csp_pkg::SEC_FACES: begin
					if (cur_slot[0]) begin
						nxt_slot = '0;
						if (cur_inner == d9) begin
							nxt_inner = neg_d9;
							nxt_outer = cur_outer + CW'(1);
						end else begin
							nxt_inner = cur_inner + CW'(1);
						end
					end else begin
						nxt_slot = cur_slot + 2'd1;
					end
				end
				default: begin
					nxt_sec   = begin_sec;
					nxt_slice = '0;
					nxt_inner = neg_d9;
					nxt_outer = neg_d9;
					nxt_slot  = '0;
					nxt_tidx  = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_radius_q <= '0;
			section_q     <= csp_pkg::SEC_ORIGIN;
			slice_y_q     <= '0;
			inner_q       <= '0;
			outer_q       <= '0;
			emit_slot_q   <= '0;
			table_index_q <= '0;
		end else if (take) begin
			held_radius_q <= cur_rad;
			section_q     <= nxt_sec;
			slice_y_q     <= nxt_slice;
			inner_q       <= nxt_inner;
			outer_q       <= nxt_outer;
			emit_slot_q   <= nxt_slot;
			table_index_q <= nxt_tidx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (take) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pos_x_q <= out_x;
			pos_y_q <= out_y;
			pos_z_q <= out_z;
			last_q  <= out_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'd0, pos_z_q, pos_y_q, pos_x_q};
	assign m_tlast  = last_q;

	`CSP_ASSERT(a_origin_radius, (section_q == csp_pkg::SEC_ORIGIN) |-> (held_radius_q == '0), "origin section with nonzero radius")
	`CSP_ASSERT(a_table_radius, (section_q == csp_pkg::SEC_TABLE) |-> (held_radius_q == RW'(1) && table_index_q < 5'(csp_pkg::TABLE_LEN)), "table section out of range")
	`CSP_ASSERT(a_slice_range, (section_q == csp_pkg::SEC_SIDEX || section_q == csp_pkg::SEC_SIDEZ) |-> (slice_y_q < held_radius_q && inner_q >= -$signed({1'b0, held_radius_q}) && inner_q <= $signed({1'b0, held_radius_q})), "side counters out of range")
	`CSP_ASSERT_NEVER(a_face_slot, section_q == csp_pkg::SEC_FACES && emit_slot_q[1], "face section slot above one")
endmodule
`default_nettype wire
